### hw/rtl/fpt_pkg.sv
// Shared constants and widths for the four-level page table mapper.
package fpt_pkg;

	localparam int unsigned POOL_PAGES_DEF = 16;
	localparam int unsigned ENTRIES_PER_TABLE = 512;
	localparam int unsigned IDX_W = 9;
	localparam int unsigned LEVELS = 4;
	localparam int unsigned PAGE_SHIFT = 12;
	localparam int unsigned VA_W = 48;
	localparam int unsigned PA_W = 52;
	localparam int unsigned FRAME_W = PA_W - PAGE_SHIFT;
	localparam int unsigned LINK_W = FRAME_W + 1;
	localparam int unsigned ENT_W = LINK_W + PAGE_SHIFT;
	localparam int unsigned PIU_W = 5;

	localparam logic [PA_W-1:0] POOL_BASE_RST = 52'd1835008;

	localparam logic [PAGE_SHIFT-1:0] LINK_FLAGS = 12'h007;
	localparam logic [PAGE_SHIFT-1:0] LEAF_FLAGS = 12'h003;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

endpackage

### hw/rtl/fpt_cfg_if.sv
// Configuration write channel carrying the table pool base address.
interface fpt_cfg_if import fpt_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [PA_W-1:0] pool_base;

	modport source (output valid, output pool_base, input ready);
	modport sink (input valid, input pool_base, output ready);
endinterface

### hw/rtl/fpt_req_if.sv
// Mapping request channel: virtual page and physical frame.
interface fpt_req_if import fpt_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [VA_W-1:0] virtual_address;
	logic [PA_W-1:0] physical_address;

	modport source (output valid, output virtual_address, output physical_address, input ready);
	modport sink (input valid, input virtual_address, input physical_address, output ready);
endinterface

### hw/rtl/fpt_rsp_if.sv
// Mapping result channel: status, leaf entry and pool usage.
interface fpt_rsp_if import fpt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             status;
	logic [PA_W-1:0]  leaf_entry;
	logic [PIU_W-1:0] pages_in_use;

	modport source (output valid, output status, output leaf_entry, output pages_in_use,
		input ready);
	modport sink (input valid, input status, input leaf_entry, input pages_in_use,
		output ready);
endinterface

### hw/rtl/four_level_page_table_mapper_unit.sv
// Four-level page table mapper: radix insert into an on-chip table pool.
// A mapping walks the single-port table memory: it reads one level at a time,
//   then writes one entry per new table plus one for the leaf; an error ends
//   the walk at a read, before any write.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: async active low; then a clearing pass zeroes all POOL_PAGES*512 pool entries,
//   during which no item is accepted (config writes are taken).
module four_level_page_table_mapper_unit import fpt_pkg::*; #(
	parameter int unsigned POOL_PAGES = POOL_PAGES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	fpt_cfg_if.sink    cfg,
	fpt_req_if.sink    req,
	fpt_rsp_if.source  rsp
);

	localparam int unsigned PG_W = $clog2(POOL_PAGES);
	localparam int unsigned DEPTH = POOL_PAGES * ENTRIES_PER_TABLE;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned NF_W = $clog2(POOL_PAGES + 1);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EV   = 3'd3;
	localparam logic [2:0] S_WR   = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	localparam logic [1:0] LVL_LEAF = 2'd3;
	localparam logic [1:0] LVL_LAST_LINK = 2'd2;

	logic [2:0]                      state_q;
	logic [AW-1:0]                   clr_q;
	logic [FRAME_W-1:0]              base_q;
	logic [LEVELS-1:0][IDX_W-1:0]    idx_q;
	logic [FRAME_W-1:0]              pa_q;
	logic [1:0]                      lvl_q;
	logic [PG_W-1:0]                 page_q;
	logic [NF_W-1:0]                 nf_q;
	logic                            err_q;

	logic                            ovalid_q;
	logic                            ostatus_q;
	logic [PA_W-1:0]                 oleaf_q;
	logic [PIU_W-1:0]                opages_q;

	logic [ENT_W-1:0]                mem [DEPTH];
	logic [ENT_W-1:0]                rd_q;
	logic [AW-1:0]                   mem_addr;
	logic                            mem_we;
	logic [ENT_W-1:0]                mem_wdata;

	logic [LINK_W-1:0]               new_link;
	logic [LINK_W:0]                 diff;
	logic                            present;
	logic                            link_ok;
	logic [NF_W:0]                   need_sum;
	logic                            fits;
	logic                            out_load;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid = ovalid_q;
	assign rsp.status = ostatus_q;
	assign rsp.leaf_entry = oleaf_q;
	assign rsp.pages_in_use = opages_q;

	// link to the next free page: pool base frame plus page number
	assign new_link = {1'b0, base_q} + LINK_W'(nf_q);

	assign present = rd_q[0];
	assign diff = {1'b0, rd_q[ENT_W-1:PAGE_SHIFT]} - {2'b00, base_q};
	assign link_ok = !diff[LINK_W] && (diff[LINK_W-1:0] != '0) &&
		(diff[LINK_W-1:0] < LINK_W'(nf_q));
	assign need_sum = {1'b0, nf_q} + (NF_W+1)'(LVL_LEAF - lvl_q);
	assign fits = (need_sum <= (NF_W+1)'(POOL_PAGES));

	assign out_load = (state_q == S_OUT) && (!ovalid_q || rsp.ready);

	always_comb begin
		mem_addr = {page_q, idx_q[lvl_q]};
		mem_we = 1'b0;
		mem_wdata = '0;
		case (state_q)
			S_CLR: begin
				mem_addr = clr_q;
				mem_we = 1'b1;
			end
			S_WR: begin
				mem_we = 1'b1;
				if (lvl_q == LVL_LEAF) begin
					mem_wdata = {1'b0, pa_q, LEAF_FLAGS};
				end else begin
					mem_wdata = {new_link, LINK_FLAGS};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			base_q <= POOL_BASE_RST[PA_W-1:PAGE_SHIFT];
			lvl_q <= '0;
			page_q <= '0;
			nf_q <= NF_W'(1);
			err_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				base_q <= cfg.pool_base[PA_W-1:PAGE_SHIFT];
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						for (int l = 0; l < LEVELS; l++) begin
							idx_q[l] <= req.virtual_address[PAGE_SHIFT + IDX_W*(LEVELS-1-l) +:
								IDX_W];
						end
						pa_q <= req.physical_address[PA_W-1:PAGE_SHIFT];
						lvl_q <= '0;
						page_q <= '0;
						err_q <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (!present) begin
						if (fits) begin
							state_q <= S_WR;
						end else begin
							err_q <= 1'b1;
							state_q <= S_OUT;
						end
					end else if (!link_ok) begin
						err_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						page_q <= diff[PG_W-1:0];
						lvl_q <= lvl_q + 2'd1;
						state_q <= (lvl_q == LVL_LAST_LINK) ? S_WR : S_RD;
					end
				end
				S_WR: begin
					if (lvl_q == LVL_LEAF) begin
						state_q <= S_OUT;
					end else begin
						page_q <= nf_q[PG_W-1:0];
						nf_q <= nf_q + NF_W'(1);
						lvl_q <= lvl_q + 2'd1;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ostatus_q <= err_q ? STATUS_ERR : STATUS_OK;
			oleaf_q <= err_q ? '0 : {pa_q, LEAF_FLAGS};
			opages_q <= PIU_W'(nf_q);
		end
	end

	a_nf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(nf_q >= NF_W'(1)) && (nf_q <= NF_W'(POOL_PAGES)))
		else $error("free page counter out of range");

	a_nf_only_in_write: assert property (@(posedge clk) disable iff (!arst_n)
		(nf_q != $past(nf_q)) |-> ($past(state_q) == S_WR))
		else $error("free page counter moved outside the write phase");

	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR) |-> !err_q)
		else $error("table write on a failed item");

	a_err_leaf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == STATUS_ERR)) |-> (rsp.leaf_entry == '0))
		else $error("error result carries a leaf entry");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |=> ((state_q == S_CLR) || (state_q == S_IDLE)))
		else $error("walk started during the clearing pass");

endmodule
